// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the clock face rtl
// expects aclk and aresetn to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define SST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define SST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/sstpg_pkg.sv =====
// shared types, constants and drawing helpers for the seven-segment clock face
// no dependencies; used by sstpg_dec_pipe and seven_segment_time_pixel_gen
package sstpg_pkg;

    // nanosecond field and its decimal form
    localparam int NS_W          = 30;
    localparam logic [NS_W-1:0] NS_MAX = 30'd999999999;
    localparam int DEC_DIGITS    = 9;
    localparam int BCD_W         = 4 * DEC_DIGITS;
    localparam int DAB_STAGES    = 6;
    localparam int DAB_BITS      = NS_W / DAB_STAGES;

    // configuration register indexes
    localparam logic [1:0] CFG_PANEL_WIDTH = 2'd0;
    localparam logic [1:0] CFG_LIT_RED     = 2'd1;
    localparam logic [1:0] CFG_LIT_GREEN   = 2'd2;
    localparam logic [1:0] CFG_LIT_BLUE    = 2'd3;

    // configuration reset values
    localparam logic [8:0] RST_PANEL_WIDTH = 9'd128;
    localparam logic [7:0] RST_LIT_RED     = 8'd255;
    localparam logic [7:0] RST_LIT_GREEN   = 8'd115;
    localparam logic [7:0] RST_LIT_BLUE    = 8'd5;

    // face geometry
    localparam logic [8:0] TOP_W = 9'd96;
    localparam logic [8:0] BOT_W = 9'd55;
    localparam int TOP_OFF [6] = '{0, 15, 34, 49, 68, 83};
    localparam int BIG_LEN     = 7;
    localparam int BIG_TH      = 3;
    localparam int SMALL_LEN   = 2;
    localparam int SMALL_TH    = 1;
    localparam int SMALL_ROW   = 25;
    localparam int SMALL_LEAD  = 3;
    localparam int SMALL_PITCH = 6;

    // segment masks, bit 6 top down to bit 0 middle
    localparam logic [6:0] SEG_TABLE [10] = '{
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
    };

    // per-pixel data that travels beside the decimal conversion
    typedef struct packed {
        logic       pre_lit;
        logic       sm_ok;
        logic [3:0] sm_idx;
        logic [1:0] sm_dx;
        logic [4:0] py;
    } side_t;

    function automatic logic in_box(input int px, input int py, input int x,
                                    input int y, input int w, input int h);
        return (px >= x) && (px < x + w) && (py >= y) && (py < y + h);
    endfunction

    // digit hit test with the digit origin at (0,0)
    function automatic logic digit_hit(input int dx, input int dy, input logic [3:0] d,
                                       input int len, input int th);
        logic [6:0] m;
        int ov;
        int hx;
        int hw;
        int rx;
        logic hit;
        ov  = (th > 1) ? 1 : 0;
        hx  = th - ov;
        hw  = len + 2 * ov;
        rx  = th + len;
        hit = 1'b0;
        m   = (d <= 4'd9) ? SEG_TABLE[d] : 7'd0;
        if (m[6] && in_box(dx, dy, hx, 0, hw, th)) hit = 1'b1;
        if (m[0] && in_box(dx, dy, hx, th + len, hw, th)) hit = 1'b1;
        if (m[3] && in_box(dx, dy, hx, 2 * th + 2 * len, hw, th)) hit = 1'b1;
        if (m[1] && in_box(dx, dy, 0, th - ov, th, hw)) hit = 1'b1;
        if (m[5] && in_box(dx, dy, rx, th - ov, th, hw)) hit = 1'b1;
        if (m[2] && in_box(dx, dy, 0, 2 * th + len - ov, th, hw)) hit = 1'b1;
        if (m[4] && in_box(dx, dy, rx, 2 * th + len - ov, th, hw)) hit = 1'b1;
        // serifs on one, four and seven
        if (d == 4'd1 || d == 4'd4 || d == 4'd7) begin
            if (in_box(dx, dy, rx - 1, 0, th + 1, th)) hit = 1'b1;
            if (in_box(dx, dy, rx - 1, 2 * th + 2 * len, th + 1, th)) hit = 1'b1;
        end
        return hit;
    endfunction

    // tens digit of a value below 64
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        t = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if (int'(v) >= 10 * k) t = 3'(k);
        end
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        return 4'(int'(v) - 10 * int'(tens_of(v)));
    endfunction

    // one shift-add-3 step of the binary to decimal conversion
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] b,
                                                     input logic in_bit);
        logic [BCD_W-1:0] adj;
        adj = b;
        for (int j = 0; j < DEC_DIGITS; j++) begin
            if (b[4*j +: 4] >= 4'd5) adj[4*j +: 4] = b[4*j +: 4] + 4'd3;
        end
        return {adj[BCD_W-2:0], in_bit};
    endfunction

    function automatic logic bcd_ok(input logic [BCD_W-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < DEC_DIGITS; j++) begin
            if (b[4*j +: 4] > 4'd9) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// ===== rtl/core/sstpg_dec_pipe.sv =====
// pipelined nanosecond to decimal conversion, side data carried alongside
// depends on sstpg_pkg and assert_macros.svh
`include "assert_macros.svh"

module sstpg_dec_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sstpg_pkg::NS_W-1:0]    in_ns,
    input  sstpg_pkg::side_t              in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sstpg_pkg::BCD_W-1:0]   out_bcd,
    output sstpg_pkg::side_t              out_side
);

    localparam int LAST = sstpg_pkg::DAB_STAGES - 1;

    logic                          vld_reg  [sstpg_pkg::DAB_STAGES];
    logic [sstpg_pkg::BCD_W-1:0]   bcd_reg  [sstpg_pkg::DAB_STAGES];
    logic [sstpg_pkg::NS_W-1:0]    bin_reg  [sstpg_pkg::DAB_STAGES];
    sstpg_pkg::side_t              side_reg [sstpg_pkg::DAB_STAGES];
    logic                          rdy      [sstpg_pkg::DAB_STAGES+1];

    assign rdy[sstpg_pkg::DAB_STAGES] = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[LAST];
    assign out_bcd   = bcd_reg[LAST];
    assign out_side  = side_reg[LAST];

    for (genvar k = 0; k < sstpg_pkg::DAB_STAGES; k++) begin : g_stage
        logic [sstpg_pkg::BCD_W-1:0] src_bcd;
        logic [sstpg_pkg::NS_W-1:0]  src_bin;
        sstpg_pkg::side_t            src_side;
        logic                        src_vld;
        logic [sstpg_pkg::BCD_W-1:0] bcd_next;
        logic [sstpg_pkg::NS_W-1:0]  bin_next;

        // stage source: input port or previous stage
        if (k == 0) begin : g_first
            assign src_bcd  = '0;
            assign src_bin  = in_ns;
            assign src_side = in_side;
            assign src_vld  = in_valid;
        end else begin : g_rest
            assign src_bcd  = bcd_reg[k-1];
            assign src_bin  = bin_reg[k-1];
            assign src_side = side_reg[k-1];
            assign src_vld  = vld_reg[k-1];
        end

        // a stage moves on when empty or when the next one moves
        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        // a few conversion steps per stage
        always_comb begin
            bcd_next = src_bcd;
            bin_next = src_bin;
            for (int j = 0; j < sstpg_pkg::DAB_BITS; j++) begin
                bcd_next = sstpg_pkg::dabble_step(bcd_next, bin_next[sstpg_pkg::NS_W-1]);
                bin_next = {bin_next[sstpg_pkg::NS_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && src_vld) begin
                bcd_reg[k]  <= bcd_next;
                bin_reg[k]  <= bin_next;
                side_reg[k] <= src_side;
            end
        end
    end

    // converted digits are always decimal
    `SST_ASSERT(a_bcd_digits, out_valid |-> sstpg_pkg::bcd_ok(out_bcd), "non-decimal digit at pipe output")
    // a stalled last stage keeps its item
    `SST_ASSERT(a_last_hold, out_valid && !out_ready |=> out_valid && $stable(out_side) && $stable(out_bcd), "pipe output changed while stalled")

endmodule

// ===== rtl/core/seven_segment_time_pixel_gen.sv =====
// seven-segment clock face pixel generator, top level
// a request passes the input register, six conversion stages and the result register
// throughput one pixel per cycle while the result side does not stall, set by the
// fully pipelined decimal conversion
// reset (synchronous, active low) empties all stages and restores the registers
// to width 128 and colour 255/115/5
// depends on sstpg_pkg, sstpg_dec_pipe and assert_macros.svh
`include "assert_macros.svh"

module seven_segment_time_pixel_gen (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_x[7:0], pixel_y[12:8], hours[17:13], minutes[23:18],
    // seconds[29:24], nanoseconds[59:30], zero[63:60]
    input  logic [63:0] s_tdata,
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_lit[0], out_red[8:1], out_green[16:9], out_blue[24:17], zero[31:25]
    output logic [31:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    // configuration registers
    logic [8:0] width_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= sstpg_pkg::RST_PANEL_WIDTH;
            red_reg   <= sstpg_pkg::RST_LIT_RED;
            green_reg <= sstpg_pkg::RST_LIT_GREEN;
            blue_reg  <= sstpg_pkg::RST_LIT_BLUE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sstpg_pkg::CFG_PANEL_WIDTH: width_reg <= cfg_data;
                sstpg_pkg::CFG_LIT_RED:     red_reg   <= cfg_data[7:0];
                sstpg_pkg::CFG_LIT_GREEN:   green_reg <= cfg_data[7:0];
                sstpg_pkg::CFG_LIT_BLUE:    blue_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register, nanoseconds saturated on the way in
    logic                       in_vld_reg;
    logic [7:0]                 px_reg;
    logic [4:0]                 py_reg;
    logic [4:0]                 hh_reg;
    logic [5:0]                 mm_reg;
    logic [5:0]                 ss_reg;
    logic [sstpg_pkg::NS_W-1:0] ns_reg;
    logic [sstpg_pkg::NS_W-1:0] ns_in;
    logic                       pipe_in_ready;

    assign ns_in    = s_tdata[59:30];
    assign s_tready = !in_vld_reg || pipe_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            px_reg <= s_tdata[7:0];
            py_reg <= s_tdata[12:8];
            hh_reg <= s_tdata[17:13];
            mm_reg <= s_tdata[23:18];
            ss_reg <= s_tdata[29:24];
            ns_reg <= (ns_in > sstpg_pkg::NS_MAX) ? sstpg_pkg::NS_MAX : ns_in;
        end
    end

    // block origins and pixel position relative to them
    logic [7:0]        top_x;
    logic [7:0]        bot_x;
    logic signed [9:0] rel_top;
    logic signed [9:0] rel_bot;
    logic [3:0]        dig [6];

    assign top_x = (width_reg >= sstpg_pkg::TOP_W) ? 8'((width_reg - sstpg_pkg::TOP_W) >> 1) : 8'd0;
    assign bot_x = (width_reg >= sstpg_pkg::BOT_W) ? 8'((width_reg - sstpg_pkg::BOT_W) >> 1) : 8'd0;
    assign rel_top = $signed({2'b00, px_reg}) - $signed({2'b00, top_x});
    assign rel_bot = $signed({2'b00, px_reg}) - $signed({2'b00, bot_x})
                   - 10'(sstpg_pkg::SMALL_LEAD);

    assign dig[0] = {1'b0, sstpg_pkg::tens_of({1'b0, hh_reg})};
    assign dig[1] = sstpg_pkg::units_of({1'b0, hh_reg});
    assign dig[2] = {1'b0, sstpg_pkg::tens_of(mm_reg)};
    assign dig[3] = sstpg_pkg::units_of(mm_reg);
    assign dig[4] = {1'b0, sstpg_pkg::tens_of(ss_reg)};
    assign dig[5] = sstpg_pkg::units_of(ss_reg);

    // large digits, colons, small colon and small digit column
    sstpg_pkg::side_t side_in;
    logic             top_hit;
    logic             clip;
    logic [3:0]       sm_idx;
    int               sm_dx;
    int               rt;
    int               rb;
    int               py_i;

    always_comb begin
        rt   = int'(rel_top);
        rb   = int'(rel_bot);
        py_i = int'(py_reg);
        top_hit = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (sstpg_pkg::digit_hit(rt - sstpg_pkg::TOP_OFF[i], py_i, dig[i],
                                     sstpg_pkg::BIG_LEN, sstpg_pkg::BIG_TH))
                top_hit = 1'b1;
        end
        if (sstpg_pkg::in_box(rt, py_i, 30, 7, 2, 2) || sstpg_pkg::in_box(rt, py_i, 30, 14, 2, 2))
            top_hit = 1'b1;
        if (sstpg_pkg::in_box(rt, py_i, 64, 7, 2, 2) || sstpg_pkg::in_box(rt, py_i, 64, 14, 2, 2))
            top_hit = 1'b1;
        if (sstpg_pkg::in_box(rb, py_i, -sstpg_pkg::SMALL_LEAD, 26, 1, 1) ||
            sstpg_pkg::in_box(rb, py_i, -sstpg_pkg::SMALL_LEAD, 29, 1, 1))
            top_hit = 1'b1;
        // which small digit column the pixel falls in
        sm_idx = 4'd0;
        for (int k = 1; k < sstpg_pkg::DEC_DIGITS; k++) begin
            if (rb >= sstpg_pkg::SMALL_PITCH * k) sm_idx = 4'(k);
        end
        sm_dx = rb - sstpg_pkg::SMALL_PITCH * int'(sm_idx);
        clip  = {1'b0, px_reg} >= width_reg;
        side_in.pre_lit = top_hit && !clip;
        side_in.sm_ok   = !clip && (rb >= 0)
                        && (rb < sstpg_pkg::SMALL_PITCH * sstpg_pkg::DEC_DIGITS)
                        && (sm_dx <= 2 * sstpg_pkg::SMALL_TH + sstpg_pkg::SMALL_LEN - 1);
        side_in.sm_idx  = sm_idx;
        side_in.sm_dx   = 2'(sm_dx);
        side_in.py      = py_reg;
    end

    // decimal conversion pipeline
    logic                        pipe_out_valid;
    logic                        pipe_out_ready;
    logic [sstpg_pkg::BCD_W-1:0] pipe_bcd;
    sstpg_pkg::side_t            pipe_side;

    sstpg_dec_pipe u_dec_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_vld_reg),
        .in_ready  (pipe_in_ready),
        .in_ns     (ns_reg),
        .in_side   (side_in),
        .out_valid (pipe_out_valid),
        .out_ready (pipe_out_ready),
        .out_bcd   (pipe_bcd),
        .out_side  (pipe_side)
    );

    // small digit test on the selected decimal digit
    logic [3:0] sm_digit;
    logic       lit_next;

    always_comb begin
        sm_digit = 4'd0;
        for (int j = 0; j < sstpg_pkg::DEC_DIGITS; j++) begin
            if (pipe_side.sm_idx == 4'(j))
                sm_digit = pipe_bcd[4*(sstpg_pkg::DEC_DIGITS-1-j) +: 4];
        end
        lit_next = pipe_side.pre_lit ||
                   (pipe_side.sm_ok &&
                    sstpg_pkg::digit_hit(int'(pipe_side.sm_dx),
                                         int'(pipe_side.py) - sstpg_pkg::SMALL_ROW,
                                         sm_digit, sstpg_pkg::SMALL_LEN, sstpg_pkg::SMALL_TH));
    end

    // result register
    logic       out_vld_reg;
    logic       lit_reg;
    logic [7:0] red_out_reg;
    logic [7:0] green_out_reg;
    logic [7:0] blue_out_reg;

    assign pipe_out_ready = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (pipe_out_ready) begin
            out_vld_reg <= pipe_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_out_ready && pipe_out_valid) begin
            lit_reg       <= lit_next;
            red_out_reg   <= lit_next ? red_reg : 8'd0;
            green_out_reg <= lit_next ? green_reg : 8'd0;
            blue_out_reg  <= lit_next ? blue_reg : 8'd0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, blue_out_reg, green_out_reg, red_out_reg, lit_reg};

    // reset empties the input and result stages
    `SST_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid && !in_vld_reg, "stage not empty after reset")
    // a new result only appears when the pipe offered one
    `SST_ASSERT(a_result_source, $rose(m_tvalid) |-> $past(pipe_out_valid), "result without pipe output")
    // a stalled input stage keeps its item
    `SST_ASSERT(a_in_hold, in_vld_reg && !pipe_in_ready |=> in_vld_reg && $stable(ns_reg) && $stable(px_reg), "input stage lost item")

endmodule

// ===== test/seven_segment_time_pixel_gen_test.sv =====
// self-checking bench for the seven-segment clock face pixel generator
// directed table then randomised pixels over several panel and colour settings
// depends on sstpg_pkg and the seven_segment_time_pixel_gen rtl
module seven_segment_time_pixel_gen_test;
    timeunit 1ns;
    timeprecision 1ps;

    // one pixel request, fields as packed into s_tdata
    typedef struct packed {
        logic [7:0]  col;
        logic [4:0]  row;
        logic [4:0]  hh;
        logic [5:0]  mm;
        logic [5:0]  ss;
        logic [29:0] ns;
    } face_req_t;

    // one pixel answer
    typedef struct packed {
        logic       lit;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } face_px_t;

    // directed table row: either a register write or a pixel request
    typedef struct packed {
        logic       is_write;
        logic [1:0] idx;
        logic [8:0] val;
        face_req_t  req;
        logic       typed;
        face_px_t   want;
    } plan_row_t;

    localparam face_px_t DARK      = '{1'b0, 8'd0, 8'd0, 8'd0};
    localparam face_px_t RESET_INK = '{1'b1, 8'd255, 8'd115, 8'd5};

    // segment masks, top segment in bit 6, middle in bit 0
    localparam logic [9:0][6:0] SEG_MASK = {7'h7B, 7'h7F, 7'h70, 7'h5F, 7'h5B,
                                            7'h33, 7'h79, 7'h6D, 7'h30, 7'h7E};
    // large digit columns relative to the top block
    localparam logic [5:0][6:0] BIG_COL = {7'd83, 7'd68, 7'd49, 7'd34, 7'd15, 7'd0};

    localparam int PHASE_ITEMS = 112;
    localparam int N_PHASES    = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = sstpg_pkg::CFG_PANEL_WIDTH;
    logic [8:0]  cfg_data = '0;

    // model copy of the registers
    logic [8:0] face_w = sstpg_pkg::RST_PANEL_WIDTH;
    logic [7:0] ink_r  = sstpg_pkg::RST_LIT_RED;
    logic [7:0] ink_g  = sstpg_pkg::RST_LIT_GREEN;
    logic [7:0] ink_b  = sstpg_pkg::RST_LIT_BLUE;

    face_px_t  expected_px [$];
    plan_row_t plan [$];
    bit        calm = 1'b0;
    bit        cfg_busy = 1'b0;
    int        errors = 0;
    int        px_sent = 0;
    int        px_checked = 0;
    int        px_lit = 0;
    int        reg_writes = 0;

    seven_segment_time_pixel_gen u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("seven_segment_time_pixel_gen verification failed");
        $finish;
    end

    function automatic bit rect_hit(int px, int py, int x, int y, int w, int h);
        return px >= x && px < x + w && py >= y && py < y + h;
    endfunction

    // one digit with its origin at (x, y)
    function automatic bit glyph_hit(int px, int py, int x, int y, int d, int len, int th);
        logic [6:0] m;
        int ov;
        int hx;
        int span;
        int rx;
        bit on;
        if (d > 9) return 1'b0;
        m    = SEG_MASK[d];
        ov   = (th > 1) ? 1 : 0;
        hx   = x + th - ov;
        span = len + 2 * ov;
        rx   = x + th + len;
        on   = 1'b0;
        if (m[6] && rect_hit(px, py, hx, y, span, th)) on = 1'b1;
        if (m[0] && rect_hit(px, py, hx, y + th + len, span, th)) on = 1'b1;
        if (m[3] && rect_hit(px, py, hx, y + 2 * th + 2 * len, span, th)) on = 1'b1;
        if (m[1] && rect_hit(px, py, x, y + th - ov, th, span)) on = 1'b1;
        if (m[5] && rect_hit(px, py, rx, y + th - ov, th, span)) on = 1'b1;
        if (m[2] && rect_hit(px, py, x, y + 2 * th + len - ov, th, span)) on = 1'b1;
        if (m[4] && rect_hit(px, py, rx, y + 2 * th + len - ov, th, span)) on = 1'b1;
        // serifs on one, four and seven
        if (d == 1 || d == 4 || d == 7) begin
            if (rect_hit(px, py, rx - 1, y, th + 1, th)) on = 1'b1;
            if (rect_hit(px, py, rx - 1, y + 2 * th + 2 * len, th + 1, th)) on = 1'b1;
        end
        return on;
    endfunction

    function automatic bit dot_pair_hit(int px, int py, int x, int y, int dot, int gap);
        return rect_hit(px, py, x, y, dot, dot) || rect_hit(px, py, x, y + dot + gap, dot, dot);
    endfunction

    // expected answer for one pixel under the current register copy
    function automatic face_px_t predict_face_px(face_req_t q);
        int w;
        int tx;
        int bx;
        int px;
        int py;
        int digit [6];
        int unsigned frac;
        bit on;
        face_px_t res;
        w  = int'(face_w);
        tx = (w >= 96) ? (w - 96) / 2 : 0;
        bx = (w >= 55) ? (w - 55) / 2 : 0;
        px = int'(q.col);
        py = int'(q.row);
        frac = q.ns;
        if (frac > 999999999) frac = 999999999;
        digit[0] = int'(q.hh) / 10;
        digit[1] = int'(q.hh) % 10;
        digit[2] = int'(q.mm) / 10;
        digit[3] = int'(q.mm) % 10;
        digit[4] = int'(q.ss) / 10;
        digit[5] = int'(q.ss) % 10;
        on = 1'b0;
        // large digits and colons
        for (int i = 0; i < 6; i++) begin
            if (glyph_hit(px, py, tx + int'(BIG_COL[i]), 0, digit[i], 7, 3)) on = 1'b1;
        end
        if (dot_pair_hit(px, py, tx + 30, 7, 2, 5)) on = 1'b1;
        if (dot_pair_hit(px, py, tx + 64, 7, 2, 5)) on = 1'b1;
        // small colon and nanosecond digits, least significant on the right
        if (dot_pair_hit(px, py, bx, 26, 1, 2)) on = 1'b1;
        for (int i = 8; i >= 0; i--) begin
            if (glyph_hit(px, py, bx + 3 + 6 * i, 25, int'(frac % 10), 2, 1)) on = 1'b1;
            frac = frac / 10;
        end
        if (px >= w) on = 1'b0;
        res = on ? face_px_t'{1'b1, ink_r, ink_g, ink_b} : DARK;
        return res;
    endfunction

    function automatic plan_row_t px_row(int x, int y, int hh, int mm, int ss, int ns,
                                         bit typed, face_px_t want);
        plan_row_t p;
        p = '0;
        p.req   = '{8'(x), 5'(y), 5'(hh), 6'(mm), 6'(ss), 30'(ns)};
        p.typed = typed;
        p.want  = want;
        return p;
    endfunction

    function automatic plan_row_t wr_row(logic [1:0] idx, logic [8:0] val);
        plan_row_t p;
        p = '0;
        p.is_write = 1'b1;
        p.idx      = idx;
        p.val      = val;
        return p;
    endfunction

    // register write request; cfg_valid is lowered by the next pixel request
    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_busy = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sstpg_pkg::CFG_PANEL_WIDTH: face_w = val;
            sstpg_pkg::CFG_LIT_RED:     ink_r  = val[7:0];
            sstpg_pkg::CFG_LIT_GREEN:   ink_g  = val[7:0];
            sstpg_pkg::CFG_LIT_BLUE:    ink_b  = val[7:0];
        endcase
        reg_writes++;
    endtask

    // pixel request with random gaps ahead of it
    task automatic send_pixel(face_req_t q, bit typed, face_px_t want);
        if (cfg_busy) begin
            cfg_valid <= 1'b0;
            cfg_busy = 1'b0;
        end
        while (!calm && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, q.ns, q.ss, q.mm, q.hh, q.row, q.col};
        do @(posedge aclk); while (!s_tready);
        expected_px.push_back(typed ? want : predict_face_px(q));
        px_sent++;
    endtask

    // let every outstanding pixel come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge aclk);
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 21);
    end

    // result checker
    always @(posedge aclk) begin
        face_px_t want;
        face_px_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[0], m_tdata[8:1], m_tdata[16:9], m_tdata[24:17]};
            if (expected_px.size() == 0) begin
                $display("%0t: unexpected result %h with no request outstanding",
                         $time, m_tdata);
                errors++;
            end else begin
                want = expected_px.pop_front();
                px_checked++;
                if (got.lit) px_lit++;
                if (got.lit !== want.lit) begin
                    $display("%0t: pixel_lit expected %0d got %0d", $time, want.lit, got.lit);
                    errors++;
                end
                if (got.r !== want.r) begin
                    $display("%0t: out_red expected %0d got %0d", $time, want.r, got.r);
                    errors++;
                end
                if (got.g !== want.g) begin
                    $display("%0t: out_green expected %0d got %0d", $time, want.g, got.g);
                    errors++;
                end
                if (got.b !== want.b) begin
                    $display("%0t: out_blue expected %0d got %0d", $time, want.b, got.b);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial begin
        face_req_t q;
        int lim;
        logic [8:0] ph_w [N_PHASES];

        // directed table, reset registers first: width 128, colour 255/115/5
        plan.push_back(px_row(255, 31, 31, 63, 63, 30'h3FFFFFFF, 1, DARK));
        plan.push_back(px_row(0, 0, 0, 0, 0, 0, 1, DARK));
        // top segment of the first large zero
        plan.push_back(px_row(18, 0, 0, 0, 0, 0, 1, RESET_INK));
        // top serif of a large one
        plan.push_back(px_row(26, 0, 10, 0, 0, 0, 1, RESET_INK));
        plan.push_back(px_row(16, 0, 0, 0, 0, 0, 1, DARK));
        // first colon, upper and lower dot
        plan.push_back(px_row(46, 7, 12, 34, 56, 0, 1, RESET_INK));
        plan.push_back(px_row(47, 15, 12, 34, 56, 0, 1, RESET_INK));
        // small colon
        plan.push_back(px_row(36, 26, 0, 0, 0, 0, 1, RESET_INK));
        // first small digit top segment
        plan.push_back(px_row(40, 25, 0, 0, 0, 0, 1, RESET_INK));
        // nanoseconds saturating
        plan.push_back(px_row(40, 25, 0, 0, 0, 30'h3FFFFFFF, 0, DARK));
        plan.push_back(px_row(86, 30, 0, 0, 0, 1000000000, 0, DARK));
        // time fields above range and in range
        plan.push_back(px_row(60, 3, 31, 63, 63, 123456789, 0, DARK));
        plan.push_back(px_row(70, 10, 12, 34, 56, 789012345, 0, DARK));
        plan.push_back(px_row(95, 20, 23, 59, 59, 999999999, 0, DARK));
        // narrow panel: both blocks at column 0, clipped at 40
        plan.push_back(wr_row(sstpg_pkg::CFG_PANEL_WIDTH, 9'd40));
        plan.push_back(px_row(2, 0, 0, 0, 0, 0, 1, RESET_INK));
        plan.push_back(px_row(40, 0, 0, 0, 0, 0, 1, DARK));
        // colours, upper data bit dropped
        plan.push_back(wr_row(sstpg_pkg::CFG_LIT_RED, 9'h1AB));
        plan.push_back(wr_row(sstpg_pkg::CFG_LIT_GREEN, 9'h000));
        plan.push_back(wr_row(sstpg_pkg::CFG_LIT_BLUE, 9'h1FF));
        plan.push_back(px_row(2, 0, 0, 0, 0, 0, 0, DARK));
        plan.push_back(wr_row(sstpg_pkg::CFG_PANEL_WIDTH, 9'h1FF));
        plan.push_back(px_row(209, 0, 0, 0, 0, 0, 0, DARK));
        plan.push_back(wr_row(sstpg_pkg::CFG_PANEL_WIDTH, 9'd0));
        plan.push_back(px_row(0, 0, 0, 0, 0, 0, 1, DARK));

        ph_w = '{9'd128, 9'd96, 9'd256, 9'd55, 9'd54, 9'd511,
                 9'($urandom_range(511)), 9'($urandom_range(256, 96))};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                drain_results();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_pixel(plan[i].req, plan[i].typed, plan[i].want);
            end
        end

        // random phases, each with fresh register settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            calm = (ph == 2);
            write_reg(sstpg_pkg::CFG_PANEL_WIDTH, ph_w[ph]);
            case (ph)
                0: begin
                    write_reg(sstpg_pkg::CFG_LIT_RED, 9'd255);
                    write_reg(sstpg_pkg::CFG_LIT_GREEN, 9'd115);
                    write_reg(sstpg_pkg::CFG_LIT_BLUE, 9'd5);
                end
                1: begin
                    write_reg(sstpg_pkg::CFG_LIT_RED, 9'd0);
                    write_reg(sstpg_pkg::CFG_LIT_GREEN, 9'd0);
                    write_reg(sstpg_pkg::CFG_LIT_BLUE, 9'd0);
                end
                2: begin
                    write_reg(sstpg_pkg::CFG_LIT_RED, 9'd255);
                    write_reg(sstpg_pkg::CFG_LIT_GREEN, 9'd255);
                    write_reg(sstpg_pkg::CFG_LIT_BLUE, 9'd255);
                end
                default: begin
                    write_reg(sstpg_pkg::CFG_LIT_RED, 9'($urandom_range(511)));
                    write_reg(sstpg_pkg::CFG_LIT_GREEN, 9'($urandom_range(511)));
                    write_reg(sstpg_pkg::CFG_LIT_BLUE, 9'($urandom_range(511)));
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mostly up to just past the visible width, sometimes anywhere
                lim = (int'(face_w) + 8 > 255) ? 255 : int'(face_w) + 8;
                q.col = ($urandom_range(3) != 0) ? 8'($urandom_range(lim)) : 8'($urandom());
                q.row = 5'($urandom());
                q.hh  = ($urandom_range(99) < 85) ? 5'($urandom_range(23)) : 5'($urandom());
                q.mm  = ($urandom_range(99) < 85) ? 6'($urandom_range(59)) : 6'($urandom());
                q.ss  = ($urandom_range(99) < 85) ? 6'($urandom_range(59)) : 6'($urandom());
                case ($urandom_range(9))
                    7:       q.ns = 30'($urandom_range(1000000010, 999999990));
                    8, 9:    q.ns = 30'($urandom());
                    default: q.ns = 30'($urandom_range(999999999));
                endcase
                send_pixel(q, 1'b0, DARK);
            end
        end
        calm = 1'b0;

        drain_results();
        // room for any stray result after the pipeline has emptied
        repeat (16) @(posedge aclk);

        $display("covered %0d pixel requests (%0d lit) and %0d register writes",
                 px_sent, px_lit, reg_writes);
        $display("panel widths from 0 to 511, times and nanoseconds beyond range included");
        if (errors == 0) begin
            $display("seven_segment_time_pixel_gen verification clean");
        end else begin
            $display("seven_segment_time_pixel_gen verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sstpg_pkg.sv
rtl/core/sstpg_dec_pipe.sv
rtl/core/seven_segment_time_pixel_gen.sv
test/seven_segment_time_pixel_gen_test.sv
